// ===== rtl/bsc_pkg.sv =====
// Shared types and constants for the breakpoint and step control block.
// Used by the table engine and the top level; depends on nothing.
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int UNIT_W  = 10;
   localparam int LINE_W  = 20;
   localparam int DEPTH_W = 16;
   localparam int KEY_W   = UNIT_W + LINE_W;
   localparam int CMD_W   = 3;

   typedef enum logic [2:0] {
      CMD_EVENT    = 3'd0,
      CMD_CONTINUE = 3'd1,
      CMD_STEP     = 3'd2,
      CMD_OVER     = 3'd3,
      CMD_OUT      = 3'd4,
      CMD_ADD      = 3'd5,
      CMD_REMOVE   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_RUNNING  = 2'd0,
      MODE_STEPPING = 2'd1,
      MODE_OVER     = 2'd2,
      MODE_OUT      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2
   } eng_op_type;

   typedef enum logic [1:0] {
      ES_IDLE  = 2'd0,
      ES_SCAN  = 2'd1,
      ES_RLAST = 2'd2,
      ES_DONE  = 2'd3
   } eng_state_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WAIT = 1'b1
   } top_state_type;

   typedef struct packed {
      logic              go;
      eng_op_type        op;
      logic [UNIT_W-1:0] unit;
      logic [LINE_W-1:0] line;
   } eng_req_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } eng_rsp_type;

endpackage

// ===== rtl/bsc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bsc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bsc_table.sv =====
// Breakpoint table engine: scans the table RAM for a key, appends, and
// removes by moving the last entry into the freed slot. Uses bsc_pkg, bsc_ram.
`timescale 1ns / 1ps

module bsc_table #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bsc_pkg::eng_req_type               eng_req,
   output bsc_pkg::eng_rsp_type               eng_rsp,
   output logic [$clog2(CAPACITY + 1)-1:0]    count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   bsc_pkg::eng_state_type state_ff, state_in;
   bsc_pkg::eng_op_type    op_ff, op_in;
   logic [bsc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          full_ff, full_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [bsc_pkg::KEY_W-1:0] wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [bsc_pkg::KEY_W-1:0] rd_data;
   logic                      match;
   logic [CW-1:0]             last;

   bsc_ram #(
      .WIDTH(bsc_pkg::KEY_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign match = (rd_data == key_ff);
   assign last  = count_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bsc_pkg::ES_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      rd_ptr_ff  <= rd_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      full_ff    <= full_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      slot_in    = slot_ff;
      full_in    = full_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = key_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_ptr_ff[AW-1:0];
      eng_rsp    = '0;

      unique case (state_ff)
         bsc_pkg::ES_IDLE: begin
            if (eng_req.go) begin
               op_in     = eng_req.op;
               key_in    = {eng_req.unit, eng_req.line};
               rd_ptr_in = '0;
               found_in  = 1'b0;
               full_in   = 1'b0;
               state_in  = bsc_pkg::ES_SCAN;
            end
         end
         bsc_pkg::ES_SCAN: begin
            // Reads are issued one per cycle; each compare lands in the cycle after its read.
            if (cmp_vld_ff && match && !found_ff) begin
               found_in = 1'b1;
               slot_in  = cmp_idx_ff;
            end
            if (rd_ptr_ff < count_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_ptr_ff[AW-1:0];
               rd_ptr_in  = rd_ptr_ff + CW'(1);
            end else if (!cmp_vld_ff) begin
               state_in = bsc_pkg::ES_DONE;
               unique case (op_ff)
                  bsc_pkg::OP_ADD: begin
                     if (!found_ff) begin
                        if (count_ff == CW'(CAPACITY)) begin
                           full_in = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  bsc_pkg::OP_REMOVE: begin
                     if (found_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = last[AW-1:0];
                        state_in = bsc_pkg::ES_RLAST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bsc_pkg::ES_RLAST: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            count_in = last;
            state_in = bsc_pkg::ES_DONE;
         end
         bsc_pkg::ES_DONE: begin
            eng_rsp.done = 1'b1;
            eng_rsp.hit  = found_ff;
            eng_rsp.full = full_ff;
            state_in     = bsc_pkg::ES_IDLE;
         end
         default: begin
            state_in = bsc_pkg::ES_IDLE;
         end
      endcase
   end

   assign count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("breakpoint count exceeds capacity");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(count_ff)) |->
         ($past(state_ff) == bsc_pkg::ES_SCAN || $past(state_ff) == bsc_pkg::ES_RLAST))
      else $error("breakpoint count changed outside an add or remove");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == bsc_pkg::ES_SCAN)
      else $error("compare pending outside the scan");

endmodule

// ===== rtl/breakpoint_and_step_control.sv =====
// Breakpoint and step control: one event or command per start beat. Mode
// commands, undefined commands and events while disabled answer 1 cycle after
// the accept, and the next beat may be taken on that cycle. Enabled events, adds
// and removes scan the table RAM one entry per cycle, and busy stays high until the
// strobe; a remove that hits also moves the last entry into the freed slot first.
// Synchronous reset empties the table, selects running.
`timescale 1ns / 1ps

module breakpoint_and_step_control #(
   parameter int CAPACITY = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bsc_pkg::CMD_W-1:0]       req_command,
   input  logic [bsc_pkg::UNIT_W-1:0]      req_unit_number,
   input  logic [bsc_pkg::LINE_W-1:0]      req_line_number,
   input  logic [bsc_pkg::DEPTH_W-1:0]     req_call_depth,
   output logic                            rsp_valid,
   output logic                            rsp_stop,
   output logic                            rsp_breakpoint_hit,
   output logic [1:0]                      rsp_run_mode,
   output logic [$clog2(CAPACITY + 1)-1:0] rsp_entry_count,
   output logic                            rsp_table_full,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   bsc_pkg::top_state_type state_ff, state_in;
   bsc_pkg::mode_type      mode_ff, mode_in;
   logic [bsc_pkg::DEPTH_W-1:0] rest_depth_ff, rest_depth_in;
   logic          enable_ff;
   logic          is_event_ff, is_event_in;
   logic          by_mode_ff, by_mode_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_stop_ff, rsp_stop_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [1:0]    rsp_mode_ff, rsp_mode_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_full_ff, rsp_full_in;

   bsc_pkg::eng_req_type eng_req;
   bsc_pkg::eng_rsp_type eng_rsp;
   logic [CW-1:0]        count;
   logic                 by_mode;
   bsc_pkg::cmd_type     cmd;

   bsc_table #(
      .CAPACITY(CAPACITY)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .eng_req(eng_req),
      .eng_rsp(eng_rsp),
      .count  (count)
   );

   assign cmd       = bsc_pkg::cmd_type'(req_command);
   assign csr_ready = 1'b1;

   always_comb begin
      unique case (mode_ff)
         bsc_pkg::MODE_STEPPING: by_mode = 1'b1;
         bsc_pkg::MODE_OVER:     by_mode = (req_call_depth <= rest_depth_ff);
         bsc_pkg::MODE_OUT:      by_mode = (req_call_depth < rest_depth_ff);
         default:                by_mode = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bsc_pkg::ST_IDLE;
         mode_ff       <= bsc_pkg::MODE_RUNNING;
         rest_depth_ff <= '0;
         enable_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         rest_depth_ff <= rest_depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
      is_event_ff  <= is_event_in;
      by_mode_ff   <= by_mode_in;
      rsp_stop_ff  <= rsp_stop_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      rest_depth_in = rest_depth_ff;
      is_event_in   = is_event_ff;
      by_mode_in    = by_mode_ff;
      rsp_valid_in  = 1'b0;
      rsp_stop_in   = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_mode_in   = mode_ff;
      rsp_count_in  = count;
      rsp_full_in   = 1'b0;
      eng_req.go    = 1'b0;
      eng_req.op    = bsc_pkg::OP_FIND;
      eng_req.unit  = req_unit_number;
      eng_req.line  = req_line_number;

      unique case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (start) begin
               is_event_in = 1'b0;
               // A mode command answers on the next cycle; table work waits.
               rsp_valid_in = 1'b1;
               unique case (cmd)
                  bsc_pkg::CMD_EVENT: begin
                     if (enable_ff) begin
                        eng_req.go   = 1'b1;
                        is_event_in  = 1'b1;
                        by_mode_in   = by_mode;
                        rsp_valid_in = 1'b0;
                        state_in     = bsc_pkg::ST_WAIT;
                     end
                  end
                  bsc_pkg::CMD_CONTINUE: mode_in = bsc_pkg::MODE_RUNNING;
                  bsc_pkg::CMD_STEP:     mode_in = bsc_pkg::MODE_STEPPING;
                  bsc_pkg::CMD_OVER: begin
                     mode_in       = bsc_pkg::MODE_OVER;
                     rest_depth_in = req_call_depth;
                  end
                  bsc_pkg::CMD_OUT: begin
                     mode_in       = bsc_pkg::MODE_OUT;
                     rest_depth_in = req_call_depth;
                  end
                  bsc_pkg::CMD_ADD: begin
                     eng_req.go   = 1'b1;
                     eng_req.op   = bsc_pkg::OP_ADD;
                     rsp_valid_in = 1'b0;
                     state_in     = bsc_pkg::ST_WAIT;
                  end
                  bsc_pkg::CMD_REMOVE: begin
                     eng_req.go   = 1'b1;
                     eng_req.op   = bsc_pkg::OP_REMOVE;
                     rsp_valid_in = 1'b0;
                     state_in     = bsc_pkg::ST_WAIT;
                  end
                  default: begin
                  end
               endcase
               rsp_mode_in = mode_in;
            end
         end
         bsc_pkg::ST_WAIT: begin
            if (eng_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = is_event_ff & eng_rsp.hit;
               rsp_stop_in  = is_event_ff & (eng_rsp.hit | by_mode_ff);
               rsp_full_in  = eng_rsp.full;
               state_in     = bsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != bsc_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stop           = rsp_stop_ff;
   assign rsp_breakpoint_hit = rsp_hit_ff;
   assign rsp_run_mode       = rsp_mode_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_table_full     = rsp_full_ff;

   a_hit_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_breakpoint_hit |-> rsp_stop)
      else $error("breakpoint hit reported without a stop");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_entry_count == CW'(CAPACITY))
      else $error("dropped add reported while the table has room");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      eng_rsp.done |-> state_ff == bsc_pkg::ST_WAIT)
      else $error("table engine finished with no item waiting");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the breakpoint and step control block: drives events
// and commands, predicts every result beat and compares it field by field.
// Depends on bsc_pkg and the breakpoint_and_step_control top level.
`timescale 1ns / 1ps

module testbench;

   localparam int CAPACITY    = 16;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int CMD_W       = bsc_pkg::CMD_W;
   localparam int UNIT_W      = bsc_pkg::UNIT_W;
   localparam int LINE_W      = bsc_pkg::LINE_W;
   localparam int DEPTH_W     = bsc_pkg::DEPTH_W;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 230;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [CMD_W-1:0]   CMD_UNDEFINED = 3'd7;
   localparam logic [UNIT_W-1:0]  UNIT_MAX      = '1;
   localparam logic [LINE_W-1:0]  LINE_MAX      = '1;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX     = '1;

   typedef struct packed {
      logic               stop;
      logic               hit;
      bsc_pkg::mode_type  run_mode;
      logic [COUNT_W-1:0] entry_count;
      logic               full;
   } stop_result_type;

   class debug_stop_scoreboard;
      bit                 enabled;
      bsc_pkg::mode_type  mode = bsc_pkg::MODE_RUNNING;
      logic [DEPTH_W-1:0] rest_depth = '0;
      int                 count;
      logic [UNIT_W-1:0]  units[CAPACITY];
      logic [LINE_W-1:0]  lines[CAPACITY];
      stop_result_type    pending_results[$];
      int                 failures, accepted, checked, stops, hits, drops;

      function int find_slot(logic [UNIT_W-1:0] unit, logic [LINE_W-1:0] line);
         for (int i = 0; i < count; i++)
            if (units[i] == unit && lines[i] == line) return i;
         return -1;
      endfunction

      // Works out the result beat of one accepted item and updates the state.
      function void note_request(logic [CMD_W-1:0] cmd, logic [UNIT_W-1:0] unit,
                                 logic [LINE_W-1:0] line, logic [DEPTH_W-1:0] depth);
         stop_result_type want;
         int              slot;
         bit              by_mode;
         want = '0;
         by_mode = 1'b0;
         case (cmd)
            bsc_pkg::CMD_EVENT: begin
               if (enabled) begin
                  want.hit = find_slot(unit, line) >= 0;
                  case (mode)
                     bsc_pkg::MODE_STEPPING: by_mode = 1'b1;
                     bsc_pkg::MODE_OVER:     by_mode = depth <= rest_depth;
                     bsc_pkg::MODE_OUT:      by_mode = depth < rest_depth;
                     default:                by_mode = 1'b0;
                  endcase
                  want.stop = by_mode || want.hit;
               end
            end
            bsc_pkg::CMD_CONTINUE: mode = bsc_pkg::MODE_RUNNING;
            bsc_pkg::CMD_STEP:     mode = bsc_pkg::MODE_STEPPING;
            bsc_pkg::CMD_OVER: begin
               mode = bsc_pkg::MODE_OVER;
               rest_depth = depth;
            end
            bsc_pkg::CMD_OUT: begin
               mode = bsc_pkg::MODE_OUT;
               rest_depth = depth;
            end
            bsc_pkg::CMD_ADD: begin
               // A duplicate is looked for first, so it never reports a full table.
               if (find_slot(unit, line) < 0) begin
                  if (count >= CAPACITY) begin
                     want.full = 1'b1;
                  end else begin
                     units[count] = unit;
                     lines[count] = line;
                     count++;
                  end
               end
            end
            bsc_pkg::CMD_REMOVE: begin
               slot = find_slot(unit, line);
               if (slot >= 0) begin
                  units[slot] = units[count-1];
                  lines[slot] = lines[count-1];
                  count--;
               end
            end
            default: ;
         endcase
         want.run_mode = mode;
         want.entry_count = count[COUNT_W-1:0];
         pending_results.push_back(want);
         accepted++;
         stops += want.stop;
         hits += want.hit;
         drops += want.full;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(stop_result_type got);
         stop_result_type want;
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation pending");
            failures++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         compare_field("stop", want.stop, got.stop);
         compare_field("breakpoint_hit", want.hit, got.hit);
         compare_field("run_mode", want.run_mode, got.run_mode);
         compare_field("entry_count", want.entry_count, got.entry_count);
         compare_field("table_full", want.full, got.full);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [CMD_W-1:0]   req_command;
   logic [UNIT_W-1:0]  req_unit_number;
   logic [LINE_W-1:0]  req_line_number;
   logic [DEPTH_W-1:0] req_call_depth;
   logic               rsp_valid;
   logic               rsp_stop;
   logic               rsp_breakpoint_hit;
   logic [1:0]         rsp_run_mode;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic               rsp_table_full;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_data;

   stop_result_type      observed;
   debug_stop_scoreboard book = new();
   int                   cycle_count;
   logic [UNIT_W-1:0]    pool_units[POOL_SIZE];
   logic [LINE_W-1:0]    pool_lines[POOL_SIZE];

   breakpoint_and_step_control #(.CAPACITY(CAPACITY)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_unit_number    (req_unit_number),
      .req_line_number    (req_line_number),
      .req_call_depth     (req_call_depth),
      .rsp_valid          (rsp_valid),
      .rsp_stop           (rsp_stop),
      .rsp_breakpoint_hit (rsp_breakpoint_hit),
      .rsp_run_mode       (rsp_run_mode),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_table_full     (rsp_table_full),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   assign observed = {rsp_stop, rsp_breakpoint_hit, rsp_run_mode, rsp_entry_count,
                      rsp_table_full};

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) book.check_response(observed);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** breakpoint_and_step_control: FAILED **");
         $finish;
      end
   end

   // Start stays high from one item to the next when there is no gap.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [UNIT_W-1:0] unit,
                            input logic [LINE_W-1:0] line,
                            input logic [DEPTH_W-1:0] depth);
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_unit_number <= unit;
      req_line_number <= line;
      req_call_depth <= depth;
      do @(posedge clock); while (busy !== 1'b0);
      book.note_request(cmd, unit, line, depth);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drains every pending result and lets the table scan run out.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (book.pending_results.size() != 0) @(negedge clock);
      repeat (CAPACITY + 6) @(negedge clock);
   endtask

   task automatic write_debug_enable(input bit value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      book.enabled = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Keys that events, adds and removes share, with the extremes and near misses.
   task automatic refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_units[i] = UNIT_W'($urandom);
         pool_lines[i] = LINE_W'($urandom);
      end
      pool_units[0] = '0;
      pool_lines[0] = '0;
      pool_units[1] = UNIT_MAX;
      pool_lines[1] = LINE_MAX;
      for (int i = 2; i < 5; i++) pool_units[i] = pool_units[i-1];
      for (int i = 5; i < 8; i++) pool_lines[i] = pool_lines[i-1];
   endtask

   task automatic run_random(input int items, input int add_weight, input bit quiet);
      int                 pick, k, d, stretch_left;
      bit                 calm;
      logic [CMD_W-1:0]   cmd;
      logic [UNIT_W-1:0]  unit;
      logic [LINE_W-1:0]  line;
      logic [DEPTH_W-1:0] depth;
      stretch_left = 0;
      calm = 1'b1;
      for (int i = 0; i < items; i++) begin
         if (!quiet) begin
            if (stretch_left == 0) begin
               calm = $urandom_range(0, 2) == 0;
               stretch_left = $urandom_range(10, 60);
            end
            stretch_left--;
            if (!calm && $urandom_range(0, 1) == 1) idle_for($urandom_range(1, 19));
         end
         if ($urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, POOL_SIZE - 1);
            unit = pool_units[k];
            line = pool_lines[k];
         end else begin
            unit = UNIT_W'($urandom);
            line = LINE_W'($urandom);
         end
         depth = DEPTH_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            cmd = bsc_pkg::CMD_EVENT;
            // Most events sit right around the latched depth.
            if ($urandom_range(0, 4) < 3) begin
               d = int'(book.rest_depth) + int'($urandom_range(0, 4)) - 2;
               if (d < 0) d = 0;
               if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
               depth = d[DEPTH_W-1:0];
            end
         end else if (pick < 44) begin
            cmd = bsc_pkg::CMD_CONTINUE;
         end else if (pick < 48) begin
            cmd = bsc_pkg::CMD_STEP;
         end else if (pick < 60) begin
            cmd = (pick < 54) ? bsc_pkg::CMD_OVER : bsc_pkg::CMD_OUT;
            if ($urandom_range(0, 1) == 1) depth = DEPTH_W'($urandom_range(0, 8));
         end else if (pick < 60 + add_weight) begin
            cmd = bsc_pkg::CMD_ADD;
         end else if (pick < 99) begin
            cmd = bsc_pkg::CMD_REMOVE;
         end else begin
            cmd = CMD_UNDEFINED;
         end
         send_item(cmd, unit, line, depth);
      end
   endtask

   initial begin
      bit enable_plan[PHASES];
      enable_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      reset = 1'b1;
      start = 1'b0;
      req_command = bsc_pkg::CMD_EVENT;
      req_unit_number = '0;
      req_line_number = '0;
      req_call_depth = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Commands act while debugging is off, but the event must not stop.
      send_item(bsc_pkg::CMD_STEP, '0, '0, '0);
      send_item(bsc_pkg::CMD_ADD, '0, '0, '0);
      send_item(bsc_pkg::CMD_EVENT, '0, '0, '0);
      settle();
      write_debug_enable(1'b1);
      send_item(bsc_pkg::CMD_EVENT, '0, '0, '0);
      send_item(bsc_pkg::CMD_ADD, UNIT_MAX, LINE_MAX, DEPTH_MAX);
      send_item(bsc_pkg::CMD_ADD, UNIT_MAX, LINE_MAX, '0);
      send_item(bsc_pkg::CMD_EVENT, UNIT_MAX, LINE_MAX, DEPTH_MAX);
      send_item(bsc_pkg::CMD_CONTINUE, '0, '0, '0);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, UNIT_MAX, LINE_MAX, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, UNIT_MAX, 20'd0, 16'd100);
      send_item(bsc_pkg::CMD_OVER, '0, '0, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, 16'd101);
      send_item(bsc_pkg::CMD_OUT, '0, '0, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, 16'd100);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, 16'd99);
      send_item(bsc_pkg::CMD_OUT, '0, '0, '0);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, '0);
      send_item(bsc_pkg::CMD_OVER, '0, '0, DEPTH_MAX);
      send_item(bsc_pkg::CMD_EVENT, 10'd5, 20'd5, DEPTH_MAX);
      send_item(bsc_pkg::CMD_REMOVE, '0, '0, '0);
      send_item(bsc_pkg::CMD_REMOVE, '0, '0, '0);
      send_item(bsc_pkg::CMD_EVENT, UNIT_MAX, LINE_MAX, '0);
      send_item(CMD_UNDEFINED, UNIT_MAX, LINE_MAX, DEPTH_MAX);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_debug_enable(enable_plan[p]);
         refresh_pool();
         if (p == 0) begin
            // Fill the table, then try two fresh adds and a duplicate on the full table.
            for (int i = 0; i < CAPACITY + 2; i++)
               send_item(bsc_pkg::CMD_ADD, pool_units[i], pool_lines[i],
                         DEPTH_W'($urandom));
            send_item(bsc_pkg::CMD_ADD, pool_units[0], pool_lines[0], DEPTH_W'($urandom));
         end
         run_random(PHASE_ITEMS, (p % 2 == 0) ? 30 : 20, p == PHASES - 1);
      end

      settle();
      $display("Ran %0d items over %0d debug-enable settings: %0d stops, %0d hits, %0d drops.",
               book.accepted, PHASES + 1, book.stops, book.hits, book.drops);
      $display("Checked %0d result beats, %0d mismatches.", book.checked, book.failures);
      if (book.failures == 0) begin
         $display("** breakpoint_and_step_control: PASSED **");
      end else begin
         $display("** breakpoint_and_step_control: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bsc_pkg.sv
rtl/bsc_ram.sv
rtl/bsc_table.sv
rtl/breakpoint_and_step_control.sv
bench/testbench.sv
